@@ rtl/core/sts_pkg.sv @@
package sts_pkg;

	localparam int KwTextLen = 10;
	localparam int NumKeywords = 63;
	localparam int KeywordMaxLenDefault = 10;
	localparam int SlotCount = 4;
	localparam int FifoDepth = 8;

	typedef enum logic [12:0] {
		M_IDLE  = 13'b0000000000001,
		M_IDENT = 13'b0000000000010,
		M_NUM   = 13'b0000000000100,
		M_STR   = 13'b0000000001000,
		M_STRQ  = 13'b0000000010000,
		M_LT    = 13'b0000000100000,
		M_GT    = 13'b0000001000000,
		M_MINUS = 13'b0000010000000,
		M_SLASH = 13'b0000100000000,
		M_DOT   = 13'b0001000000000,
		M_LCOM  = 13'b0010000000000,
		M_BCOM  = 13'b0100000000000,
		M_BSTAR = 13'b1000000000000
	} scan_mode_t;

	localparam logic [3:0] C_IDENT   = 4'd0;
	localparam logic [3:0] C_KEYWORD = 4'd1;
	localparam logic [3:0] C_INT     = 4'd2;
	localparam logic [3:0] C_FLOAT   = 4'd3;
	localparam logic [3:0] C_STRING  = 4'd4;
	localparam logic [3:0] C_BYTEA   = 4'd5;
	localparam logic [3:0] C_OP      = 4'd6;
	localparam logic [3:0] C_EOF     = 4'd7;
	localparam logic [3:0] C_ERROR   = 4'd8;

	localparam logic [5:0] OP_LPAREN = 6'd0;
	localparam logic [5:0] OP_RPAREN = 6'd1;
	localparam logic [5:0] OP_COMMA  = 6'd2;
	localparam logic [5:0] OP_SEMI   = 6'd3;
	localparam logic [5:0] OP_EQ     = 6'd4;
	localparam logic [5:0] OP_NE     = 6'd5;
	localparam logic [5:0] OP_LE     = 6'd6;
	localparam logic [5:0] OP_LT     = 6'd7;
	localparam logic [5:0] OP_GE     = 6'd8;
	localparam logic [5:0] OP_GT     = 6'd9;
	localparam logic [5:0] OP_PLUS   = 6'd10;
	localparam logic [5:0] OP_MINUS  = 6'd11;
	localparam logic [5:0] OP_STAR   = 6'd12;
	localparam logic [5:0] OP_SLASH  = 6'd13;
	localparam logic [5:0] OP_DOT    = 6'd14;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_query;
	} query_item_t;

	typedef struct packed {
		logic [3:0]  token_class;
		logic [5:0]  token_code;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic        last;
	} token_item_t;

	typedef struct packed {
		logic hit;
		logic [5:0] code;
	} kw_result_t;

	localparam logic [8*KwTextLen-1:0] KW_TEXT [NumKeywords] = '{
		"or", "if", "by", "as", "is", "on", "to",
		"key", "and", "not", "set", "asc", "avg", "sum", "max", "min",
		"text", "into", "from", "bool", "null", "true", "drop", "desc",
		"join", "left", "full", "int8", "cast", "like",
		"table", "where", "bytea", "false", "order", "limit", "group",
		"count", "cross", "inner", "right", "nulls", "begin", "model",
		"create", "float4", "insert", "values", "select", "update", "delete",
		"exists", "unique", "commit", "having",
		"primary", "foreign", "similar",
		"describe", "distinct", "rollback",
		"timestamp",
		"references"
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	function automatic token_item_t mk_token(input logic [3:0] cls, input logic [5:0] code,
			input logic [15:0] start, input logic [15:0] len, input logic last);
		token_item_t t;
		t.token_class = cls;
		t.token_code = code;
		t.start_offset = start;
		t.token_length = len;
		t.last = last;
		return t;
	endfunction

	// Keyword text is right-aligned, so byte i of a keyword of length n sits at n-1-i.
	function automatic kw_result_t kw_match(input logic [KwTextLen-1:0][7:0] w,
			input logic [15:0] n);
		kw_result_t r;
		int len;
		logic ok;
		r = '0;
		for (int k = 0; k < NumKeywords; k++) begin
			len = 0;
			for (int j = 0; j < KwTextLen; j++) begin
				if (KW_TEXT[k][j*8 +: 8] != 8'd0) begin
					len++;
				end
			end
			ok = (n == 16'(len));
			for (int i = 0; i < KwTextLen; i++) begin
				if (i < len && KW_TEXT[k][(len-1-i)*8 +: 8] != w[i]) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				r.hit = 1'b1;
				r.code = 6'(k);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sts_stream_if.sv @@
interface sts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sts_lexer_core.sv @@
module sts_lexer_core #(
	parameter int KeywordMaxLen = sts_pkg::KeywordMaxLenDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  sts_pkg::query_item_t    item,
	output logic [sts_pkg::SlotCount-1:0] slot_valid,
	output sts_pkg::token_item_t    slot_token [sts_pkg::SlotCount]
);
	localparam int IdxW = $clog2(KeywordMaxLen);

	sts_pkg::scan_mode_t mode_q, m;
	logic [15:0] pos_q, np, ts_q, ts, tc_q, tc;
	logic        sd_q, sd, st_q, st, used;
	logic [7:0]  buf_q [KeywordMaxLen];
	logic [7:0]  nb [KeywordMaxLen];
	logic [7:0]  c;
	logic [sts_pkg::KwTextLen-1:0][7:0] w, w_end;
	sts_pkg::kw_result_t kw, kw_end;
	sts_pkg::token_item_t word_tok, str_tok;

	always_comb begin
		m = mode_q;
		ts = ts_q;
		tc = tc_q;
		sd = sd_q;
		st = st_q;
		nb = buf_q;
		np = pos_q;
		used = 1'b0;
		c = item.char_code;
		w_end = '0;
		kw_end = '0;
		slot_valid = '0;
		for (int k = 0; k < sts_pkg::SlotCount; k++) begin
			slot_token[k] = '0;
		end
		for (int i = 0; i < sts_pkg::KwTextLen; i++) begin
			w[i] = buf_q[i];
		end
		kw = sts_pkg::kw_match(w, tc_q);
		word_tok = sts_pkg::mk_token(
			(kw.hit && tc_q >= 16'd2 && tc_q <= 16'(KeywordMaxLen)) ?
				sts_pkg::C_KEYWORD : sts_pkg::C_IDENT,
			(kw.hit && tc_q >= 16'd2 && tc_q <= 16'(KeywordMaxLen)) ? kw.code : 6'd0,
			ts_q, tc_q, 1'b0);
		str_tok = sts_pkg::mk_token(
			(tc_q >= 16'd2 && buf_q[0] == 8'h5C && buf_q[1] == "x") ?
				sts_pkg::C_BYTEA : sts_pkg::C_STRING, 6'd0, ts_q, tc_q, 1'b0);
		if (accept && !st_q) begin
			unique case (mode_q)
				sts_pkg::M_IDLE: begin
				end
				sts_pkg::M_IDENT: begin
					if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
						if (tc < 16'(KeywordMaxLen)) begin
							nb[tc[IdxW-1:0]] = sts_pkg::to_lower(c);
						end
						tc = sts_pkg::sat_inc(tc);
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = word_tok;
					end
				end
				sts_pkg::M_NUM: begin
					if (sts_pkg::is_digit(c) || c == ".") begin
						if (c == ".") begin
							sd = 1'b1;
						end
						tc = sts_pkg::sat_inc(tc);
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = sts_pkg::mk_token(sd_q ? sts_pkg::C_FLOAT : sts_pkg::C_INT,
							6'd0, ts_q, tc_q, 1'b0);
					end
				end
				sts_pkg::M_DOT: begin
					if (sts_pkg::is_digit(c)) begin
						m = sts_pkg::M_NUM;
						sd = 1'b1;
						tc = 16'd2;
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_DOT, ts_q,
							16'd1, 1'b0);
					end
				end
				sts_pkg::M_STR: begin
					if (c == "'") begin
						m = sts_pkg::M_STRQ;
					end else begin
						if (tc < 16'd2) begin
							nb[tc[0]] = c;
						end
						tc = sts_pkg::sat_inc(tc);
					end
					used = 1'b1;
				end
				sts_pkg::M_STRQ: begin
					if (c == "'") begin
						if (tc < 16'd2) begin
							nb[tc[0]] = c;
						end
						tc = sts_pkg::sat_inc(tc);
						if (tc < 16'd2) begin
							nb[tc[0]] = c;
						end
						tc = sts_pkg::sat_inc(tc);
						m = sts_pkg::M_STR;
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = str_tok;
					end
				end
				sts_pkg::M_LT: begin
					slot_valid[0] = 1'b1;
					if (c == ">" || c == "=") begin
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP,
							(c == ">") ? sts_pkg::OP_NE : sts_pkg::OP_LE, ts_q, 16'd2, 1'b0);
						m = sts_pkg::M_IDLE;
						used = 1'b1;
					end else begin
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_LT, ts_q,
							16'd1, 1'b0);
					end
				end
				sts_pkg::M_GT: begin
					slot_valid[0] = 1'b1;
					if (c == "=") begin
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_GE, ts_q,
							16'd2, 1'b0);
						m = sts_pkg::M_IDLE;
						used = 1'b1;
					end else begin
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_GT, ts_q,
							16'd1, 1'b0);
					end
				end
				sts_pkg::M_MINUS: begin
					if (c == "-") begin
						m = sts_pkg::M_LCOM;
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_MINUS, ts_q,
							16'd1, 1'b0);
					end
				end
				sts_pkg::M_SLASH: begin
					if (c == "*") begin
						m = sts_pkg::M_BCOM;
						used = 1'b1;
					end else begin
						slot_valid[0] = 1'b1;
						slot_token[0] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_SLASH, ts_q,
							16'd1, 1'b0);
					end
				end
				sts_pkg::M_LCOM: begin
					used = (c != 8'h0A);
				end
				sts_pkg::M_BCOM: begin
					if (c == "*") begin
						m = sts_pkg::M_BSTAR;
					end
					used = 1'b1;
				end
				sts_pkg::M_BSTAR: begin
					if (c == "/") begin
						m = sts_pkg::M_IDLE;
					end else if (c != "*") begin
						m = sts_pkg::M_BCOM;
					end
					used = 1'b1;
				end
				default: begin
				end
			endcase
			if (!used) begin
				m = sts_pkg::M_IDLE;
				ts = pos_q;
				if (sts_pkg::is_space(c)) begin
				end else if (sts_pkg::is_alpha(c)) begin
					m = sts_pkg::M_IDENT;
					nb[0] = sts_pkg::to_lower(c);
					tc = 16'd1;
				end else if (sts_pkg::is_digit(c)) begin
					m = sts_pkg::M_NUM;
					sd = 1'b0;
					tc = 16'd1;
				end else if (c == "'") begin
					m = sts_pkg::M_STR;
					ts = pos_q + 16'd1;
					tc = 16'd0;
				end else if (c == ".") begin
					m = sts_pkg::M_DOT;
				end else if (c == "<") begin
					m = sts_pkg::M_LT;
				end else if (c == ">") begin
					m = sts_pkg::M_GT;
				end else if (c == "-") begin
					m = sts_pkg::M_MINUS;
				end else if (c == "/") begin
					m = sts_pkg::M_SLASH;
				end else begin
					slot_valid[1] = 1'b1;
					case (c)
						"(": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_LPAREN,
							pos_q, 16'd1, 1'b0);
						")": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_RPAREN,
							pos_q, 16'd1, 1'b0);
						",": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_COMMA,
							pos_q, 16'd1, 1'b0);
						";": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_SEMI,
							pos_q, 16'd1, 1'b0);
						"=": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_EQ,
							pos_q, 16'd1, 1'b0);
						"+": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_PLUS,
							pos_q, 16'd1, 1'b0);
						"*": slot_token[1] = sts_pkg::mk_token(sts_pkg::C_OP, sts_pkg::OP_STAR,
							pos_q, 16'd1, 1'b0);
						default: begin
							slot_token[1] = sts_pkg::mk_token(sts_pkg::C_ERROR, 6'd0, pos_q,
								16'd1, 1'b1);
							st = 1'b1;
						end
					endcase
				end
			end
			np = pos_q + 16'd1;
			if (item.end_of_query && !st) begin
				slot_valid[2] = (m != sts_pkg::M_IDLE) && (m != sts_pkg::M_LCOM) &&
					(m != sts_pkg::M_BCOM) && (m != sts_pkg::M_BSTAR);
				unique case (m)
					sts_pkg::M_IDENT: begin
						for (int i = 0; i < sts_pkg::KwTextLen; i++) begin
							w_end[i] = nb[i];
						end
						kw_end = sts_pkg::kw_match(w_end, tc);
						slot_token[2] = sts_pkg::mk_token(
							(kw_end.hit && tc >= 16'd2 && tc <= 16'(KeywordMaxLen)) ?
								sts_pkg::C_KEYWORD : sts_pkg::C_IDENT,
							(kw_end.hit && tc >= 16'd2 && tc <= 16'(KeywordMaxLen)) ?
								kw_end.code : 6'd0,
							ts, tc, 1'b0);
					end
					sts_pkg::M_NUM: slot_token[2] = sts_pkg::mk_token(
						sd ? sts_pkg::C_FLOAT : sts_pkg::C_INT, 6'd0, ts, tc, 1'b0);
					sts_pkg::M_DOT: slot_token[2] = sts_pkg::mk_token(sts_pkg::C_OP,
						sts_pkg::OP_DOT, ts, 16'd1, 1'b0);
					sts_pkg::M_STRQ: slot_token[2] = str_tok;
					sts_pkg::M_LT: slot_token[2] = sts_pkg::mk_token(sts_pkg::C_OP,
						sts_pkg::OP_LT, ts, 16'd1, 1'b0);
					sts_pkg::M_GT: slot_token[2] = sts_pkg::mk_token(sts_pkg::C_OP,
						sts_pkg::OP_GT, ts, 16'd1, 1'b0);
					sts_pkg::M_MINUS: slot_token[2] = sts_pkg::mk_token(sts_pkg::C_OP,
						sts_pkg::OP_MINUS, ts, 16'd1, 1'b0);
					sts_pkg::M_SLASH: slot_token[2] = sts_pkg::mk_token(sts_pkg::C_OP,
						sts_pkg::OP_SLASH, ts, 16'd1, 1'b0);
					sts_pkg::M_STR: begin
						slot_token[2] = sts_pkg::mk_token(sts_pkg::C_ERROR, 6'd0, ts, tc, 1'b1);
						st = 1'b1;
					end
					default: begin
					end
				endcase
				slot_valid[3] = !st;
				slot_token[3] = sts_pkg::mk_token(sts_pkg::C_EOF, 6'd0, np, 16'd0, 1'b1);
			end
		end
		if (accept && item.end_of_query) begin
			m = sts_pkg::M_IDLE;
			np = '0;
			ts = '0;
			tc = '0;
			sd = 1'b0;
			st = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::M_IDLE;
			pos_q <= '0;
			ts_q <= '0;
			tc_q <= '0;
			sd_q <= 1'b0;
			st_q <= 1'b0;
		end else if (accept) begin
			mode_q <= m;
			pos_q <= np;
			ts_q <= ts;
			tc_q <= tc;
			sd_q <= sd;
			st_q <= st;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= nb;
		end
	end
endmodule

@@ rtl/core/sts_token_fifo.sv @@
module sts_token_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sts_pkg::SlotCount-1:0] push_valid,
	input  sts_pkg::token_item_t          push_token [sts_pkg::SlotCount],
	output logic                          has_room,
	sts_stream_if.source                  token
);
	localparam int PtrW = $clog2(sts_pkg::FifoDepth);

	sts_pkg::token_item_t mem_q [sts_pkg::FifoDepth];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [PtrW:0]   count_q, npush;
	logic            pop;

	always_comb begin
		npush = '0;
		for (int k = 0; k < sts_pkg::SlotCount; k++) begin
			npush = npush + (PtrW+1)'(push_valid[k]);
		end
	end

	assign pop = token.valid && token.ready;
	assign token.valid = (count_q != '0);
	assign token.data = mem_q[rptr_q];
	assign has_room = (count_q <= (PtrW+1)'(sts_pkg::FifoDepth - sts_pkg::SlotCount));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + npush[PtrW-1:0];
			rptr_q <= rptr_q + PtrW'(pop);
			count_q <= count_q + npush - (PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		logic [PtrW-1:0] a;
		a = wptr_q;
		for (int k = 0; k < sts_pkg::SlotCount; k++) begin
			if (push_valid[k]) begin
				mem_q[a] <= push_token[k];
				a = a + PtrW'(1);
			end
		end
	end
endmodule

@@ rtl/core/sql_token_scanner.sv @@
// SQL token scanner.
// The query channel carries one byte per transaction with an end flag on the
// final byte of the query. The token channel carries one token per
// transaction: class, code, start offset, length and a last flag, which is set
// on the closing end-of-query or error token.
// A byte is accepted in every cycle while the output queue has room for
// four tokens, one per slot, though one byte produces at most three; the scan
// state and keyword compare settle in the cycle of acceptance and the tokens
// are written into an eight-entry queue, so with an empty queue the first
// token is visible in the cycle after its byte. Sustained input rate is one
// byte per cycle, limited on the output side to one token per cycle.
// When the receiver stalls, queued tokens hold and input stops once fewer
// than four queue entries are free.
// After an invalid byte the rest of the query is consumed without output.
// After reset the scanner is idle with offset zero and an empty queue; after
// the final byte of each query it is idle again with offset zero.
module sql_token_scanner #(
	parameter int KEYWORD_MAX_LEN = sts_pkg::KeywordMaxLenDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	sts_stream_if.sink   query,
	sts_stream_if.source token
);
	logic                          accept, room;
	logic [sts_pkg::SlotCount-1:0] slot_valid;
	sts_pkg::token_item_t          slot_token [sts_pkg::SlotCount];

	assign query.ready = room;
	assign accept = query.valid && room;

	sts_lexer_core #(.KeywordMaxLen(KEYWORD_MAX_LEN)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (query.data),
		.slot_valid (slot_valid),
		.slot_token (slot_token)
	);

	sts_token_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (slot_valid),
		.push_token (slot_token),
		.has_room   (room),
		.token      (token)
	);
endmodule
